// ===== hdl/dq_pkg.sv =====
// Shared constants and codes for the double-ended queue.
`default_nettype none

package dq_pkg;

   localparam int DEPTH_DEFAULT      = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the ports.
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int RANK_W   = 3;
   localparam int OCC_W    = 4;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_PUSH_FRONT = 2'd0;
   localparam action_type ACT_POP_FRONT  = 2'd1;
   localparam action_type ACT_PUSH_BACK  = 2'd2;
   localparam action_type ACT_POP_BACK   = 2'd3;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// Bounded double-ended queue held in a circular buffer memory, with a contents walk per action.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | action, data_value
//  rsp     | out       | rsp_valid/rsp_stall | status, has_entry, entry_value, entry_rank,
//          |           |                     | occupancy, last
//
// An accepted action updates the memory and the pointers. The first read issues in the next
// cycle and the walk then reads one element per cycle from the single read port while rsp
// is not stalled, giving one result per element held afterward, or a single result with no
// entry when the queue is then empty.
// A stall on rsp holds the presented result and pauses the walk; req stays stalled until
// the last result of the walk is transferred. Reset empties the queue; no clearing pass.
`default_nettype none

module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [ACTION_W-1:0]        req_action,
   input  wire logic signed [VALUE_W-1:0]  req_data_value,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [STATUS_W-1:0]        rsp_status,
   output      logic                       rsp_has_entry,
   output      logic signed [VALUE_W-1:0]  rsp_entry_value,
   output      logic [RANK_W-1:0]          rsp_entry_rank,
   output      logic [OCC_W-1:0]           rsp_occupancy,
   output      logic                       rsp_last
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [SW-1:0] WRAP       = SW'(DEPTH);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   logic [IW-1:0]    front_ff, front_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             issued_ff, issued_in;
   logic [CW-1:0]    walk_ff, walk_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             has_ff, has_in;
   logic             last_ff, last_in;
   logic [IW-1:0]    rank_ff, rank_in;

   logic                  accept, out_xfer, issue, rd_en, wr_en;
   logic [IW-1:0]         waddr, raddr, front_dec;
   logic [SW-1:0]         back_sum, rd_sum;
   logic [DATA_WIDTH-1:0] wdata;
   logic [63:0]           rd_ext;

   assign accept   = req_valid && !busy_ff;
   assign out_xfer = rsp_valid_ff && !rsp_stall;
   assign issue    = busy_ff && !issued_ff && (!rsp_valid_ff || !rsp_stall);
   assign rd_en    = issue && (count_ff != '0);

   assign wdata     = DATA_WIDTH'({32'd0, req_data_value});
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
   assign back_sum  = SW'(front_ff) + SW'(count_ff);
   assign rd_sum    = SW'(front_ff) + SW'(walk_ff);
   assign raddr     = (rd_sum >= WRAP) ? IW'(rd_sum - WRAP) : IW'(rd_sum);

   // Action processing: pointer update and memory write for pushes.
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      waddr     = IW'(0);
      if (accept) begin
         status_in = ST_DONE;
         unique case (req_action)
            ACT_PUSH_FRONT: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  waddr    = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_PUSH_BACK: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  waddr    = (back_sum >= WRAP) ? IW'(back_sum - WRAP) : IW'(back_sum);
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_POP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  front_in = (front_ff == LAST_SLOT) ? IW'(0) : front_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Contents walk: one read per free output slot, results follow the read data.
   always_comb begin
      busy_in      = busy_ff;
      issued_in    = issued_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff;
      has_in       = has_ff;
      last_in      = last_ff;
      rank_in      = rank_ff;
      if (accept) begin
         busy_in   = 1'b1;
         issued_in = 1'b0;
         walk_in   = '0;
      end else if (issue) begin
         rsp_valid_in = 1'b1;
         has_in       = (count_ff != '0);
         rank_in      = IW'(walk_ff);
         if (count_ff == '0 || walk_ff == count_ff - 1'b1) begin
            last_in   = 1'b1;
            issued_in = 1'b1;
         end else begin
            last_in = 1'b0;
         end
         walk_in = walk_ff + 1'b1;
      end else if (out_xfer) begin
         rsp_valid_in = 1'b0;
         if (last_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         issued_ff    <= 1'b0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         issued_ff    <= issued_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      has_ff    <= has_in;
      last_ff   <= last_in;
      rank_ff   <= rank_in;
   end

   assign rd_ext = 64'($signed(rdata_ff));

   assign req_stall       = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_has_entry   = has_ff;
   assign rsp_entry_value = has_ff ? rd_ext[VALUE_W-1:0] : '0;
   assign rsp_entry_rank  = has_ff ? RANK_W'(rank_ff) : '0;
   assign rsp_occupancy   = OCC_W'(count_ff);
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

// ===== bench/double_ended_queue_test.sv =====
// Self-checking testbench for the double-ended queue: predicts each contents walk.
`timescale 1ns / 100ps

import dq_pkg::*;

typedef struct packed {
   status_type          status;
   logic                has_entry;
   logic [VALUE_W-1:0]  value;
   logic [RANK_W-1:0]   rank;
   logic [OCC_W-1:0]    occupancy;
   logic                last;
} walk_result_type;

class deque_tracker;
   int                 capacity;
   logic [VALUE_W-1:0] contents[$];
   walk_result_type    expected_walk[$];
   int                 mismatches;

   function new(int depth);
      capacity = depth;
      mismatches = 0;
   endfunction

   function int pending();
      return expected_walk.size();
   endfunction

   // Applies one accepted action to the local copy and queues the walk it causes.
   function void note_action(action_type act, logic [VALUE_W-1:0] value);
      status_type      st;
      walk_result_type r;
      int              n;
      st = ST_DONE;
      case (act)
         ACT_PUSH_FRONT: begin
            if (contents.size() >= capacity) st = ST_FULL;
            else contents.push_front(value);
         end
         ACT_PUSH_BACK: begin
            if (contents.size() >= capacity) st = ST_FULL;
            else contents.push_back(value);
         end
         ACT_POP_FRONT: begin
            if (contents.size() == 0) st = ST_EMPTY;
            else void'(contents.pop_front());
         end
         default: begin
            if (contents.size() == 0) st = ST_EMPTY;
            else void'(contents.pop_back());
         end
      endcase
      n = contents.size();
      if (n == 0) begin
         r.status = st;
         r.has_entry = 1'b0;
         r.value = '0;
         r.rank = '0;
         r.occupancy = '0;
         r.last = 1'b1;
         expected_walk.push_back(r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.status = st;
            r.has_entry = 1'b1;
            r.value = contents[k];
            r.rank = k[RANK_W-1:0];
            r.occupancy = n[OCC_W-1:0];
            r.last = (k == n - 1);
            expected_walk.push_back(r);
         end
      end
   endfunction

   function void check_walk_result(walk_result_type got);
      walk_result_type want;
      if (expected_walk.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected result at %0t:", $time);
            $display("   got status %0d has_entry %0d value %h rank %0d occ %0d last %0d",
                     got.status, got.has_entry, got.value, got.rank, got.occupancy, got.last);
         end
         return;
      end
      want = expected_walk.pop_front();
      if (got.status != want.status || got.has_entry != want.has_entry ||
          got.value != want.value || got.rank != want.rank ||
          got.occupancy != want.occupancy || got.last != want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch at %0t:", $time);
            $display("   expected status %0d has_entry %0d value %h rank %0d occ %0d last %0d",
                     want.status, want.has_entry, want.value, want.rank, want.occupancy,
                     want.last);
            $display("   got      status %0d has_entry %0d value %h rank %0d occ %0d last %0d",
                     got.status, got.has_entry, got.value, got.rank, got.occupancy, got.last);
         end
      end
   endfunction
endclass

module double_ended_queue_test;

   localparam int DEQUE_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 500000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   action_type                req_action;
   logic signed [VALUE_W-1:0] req_data_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_has_entry;
   logic signed [VALUE_W-1:0] rsp_entry_value;
   logic [RANK_W-1:0]         rsp_entry_rank;
   logic [OCC_W-1:0]          rsp_occupancy;
   logic                      rsp_last;

   deque_tracker tracker = new(DEQUE_DEPTH);

   int cycle_count;
   int hold_request;
   bit rsp_pacing_on;
   int push_pct;

   double_ended_queue #(
      .DEPTH      (DEQUE_DEPTH),
      .DATA_WIDTH (DATA_WIDTH_DEFAULT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_data_value  (req_data_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_has_entry   (rsp_has_entry),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_rank  (rsp_entry_rank),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Inputs are noted before results are checked, so ordering within an edge cannot matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_action(req_action, req_data_value);
         if (rsp_valid && !rsp_stall)
            tracker.check_walk_result('{rsp_status, rsp_has_entry, rsp_entry_value,
                                        rsp_entry_rank, rsp_occupancy, rsp_last});
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic action_type pick_action(int pct);
      if ($urandom_range(0, 99) < pct)
         return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
   endfunction

   // Receiver pacing; a requested hold-off is counted here in its own process.
   initial begin : rsp_pacing
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_stall = 1'b1;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
            rsp_stall = 1'b0;
         end else if (rsp_pacing_on && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat (pick_gap() + 1) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic offer(action_type act, logic [VALUE_W-1:0] value);
      req_action = act;
      req_data_value = value;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic wait_for_walks();
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic random_actions(int count, bit with_gaps);
      for (int i = 0; i < count; i++) begin
         // Alternate between filling and draining runs so both ends are reached often.
         if (i % 16 == 0) push_pct = (push_pct == 75) ? 25 : 75;
         offer(pick_action(push_pct), pick_value());
         if (with_gaps) pause_sender(pick_gap());
      end
   endtask

   initial begin : cycle_watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("double_ended_queue_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_POP_FRONT;
      req_data_value = '0;
      hold_request = 0;
      rsp_pacing_on = 1'b0;
      push_pct = 25;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: pops on empty, lone element, shifts at both edges, full refusals, drain.
      offer(ACT_POP_FRONT, 32'h1111_1111);
      offer(ACT_POP_BACK, 32'h2222_2222);
      offer(ACT_PUSH_FRONT, 32'h8000_0000);
      offer(ACT_POP_BACK, 32'h0);
      offer(ACT_PUSH_BACK, 32'h7fff_ffff);
      offer(ACT_PUSH_FRONT, 32'hffff_ffff);
      offer(ACT_PUSH_FRONT, 32'h0000_0000);
      for (int i = 1; i <= 5; i++) offer(ACT_PUSH_BACK, i);
      offer(ACT_PUSH_BACK, 32'h5555_5555);
      offer(ACT_PUSH_FRONT, 32'haaaa_aaaa);
      offer(ACT_POP_FRONT, 32'h0);
      offer(ACT_PUSH_BACK, 32'h1234_5678);
      for (int i = 0; i < DEQUE_DEPTH; i++)
         offer(i[0] ? ACT_POP_BACK : ACT_POP_FRONT, 32'h0);
      offer(ACT_POP_BACK, 32'h0);

      rsp_pacing_on = 1'b1;
      random_actions(100, 1'b1);

      // A stretch with no idling on either side.
      wait_for_walks();
      rsp_pacing_on = 1'b0;
      random_actions(50, 1'b0);

      // Long receiver hold-off while the sender keeps offering.
      hold_request = 80;
      random_actions(20, 1'b0);

      // The sender waits until every walk has been transferred.
      wait_for_walks();
      pause_sender(5);

      rsp_pacing_on = 1'b1;
      random_actions(75, 1'b1);

      wait_for_walks();
      repeat (2 * DEQUE_DEPTH + 4) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("double_ended_queue_test: PASS");
      else
         $display("double_ended_queue_test: FAIL");
      $finish;
   end

endmodule
